>>> hw/rtl/mrds_pkg.sv
// Shared types, port codes and register indexes for the mesh route direction select block.
// No dependencies; every module of the block imports this package.
`default_nettype none

package mrds_pkg;

    // Coordinate, register and label widths
    localparam int unsigned COORD_W = 4;
    localparam int unsigned DIM_W   = 5;
    localparam int unsigned LABEL_W = 9;
    localparam int unsigned MASK_W  = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 5;

    // Output port bits
    localparam logic [MASK_W-1:0] PORT_NONE  = 4'b0000;
    localparam logic [MASK_W-1:0] PORT_NORTH = 4'b0001;
    localparam logic [MASK_W-1:0] PORT_EAST  = 4'b0010;
    localparam logic [MASK_W-1:0] PORT_SOUTH = 4'b0100;
    localparam logic [MASK_W-1:0] PORT_WEST  = 4'b1000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MESH_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BROADCAST_MODE = 2'd2;

    // One routing request
    typedef struct packed {
        logic [COORD_W-1:0] cur_x;
        logic [COORD_W-1:0] cur_y;
        logic [COORD_W-1:0] src_x;
        logic [COORD_W-1:0] src_y;
        logic [COORD_W-1:0] dst_x;
        logic [COORD_W-1:0] dst_y;
        logic               is_broadcast;
    } item_t;

    // First stage: request with the effective mesh size and mode
    typedef struct packed {
        item_t            item;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic             path_mode;
    } s1_t;

    // Second stage: labels and candidate masks
    typedef struct packed {
        logic [LABEL_W-1:0] cur_label;
        logic [LABEL_W-1:0] home_label;
        logic               is_broadcast;
        logic               path_mode;
        logic               in_range;
        logic               at_first;
        logic               at_last;
        logic [MASK_W-1:0]  fwd_dir;
        logic [MASK_W-1:0]  bwd_dir;
        logic [MASK_W-1:0]  uni_mask;
        logic [MASK_W-1:0]  tree_mask;
    } s2_t;

    // Row-snake label: even rows run left to right, odd rows right to left
    function automatic logic [LABEL_W-1:0] label_of(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic [DIM_W-1:0]   w
    );
        logic [LABEL_W-1:0] row_base;
        logic [LABEL_W-1:0] col;
        row_base = LABEL_W'(y) * LABEL_W'(w);
        if (y[0] == 1'b0)
        begin
            col = LABEL_W'(x);
        end
        else
        begin
            col = LABEL_W'(w) - LABEL_W'(x) - LABEL_W'(1);
        end
        return row_base + col;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mrds_front.sv
// Input stage: captures a request beat and clamps the mesh size registers.
// Depends on mrds_pkg.
`default_nettype none

module mrds_front #(
    parameter int unsigned MAX_MESH_DIM = 16
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire mrds_pkg::item_t              in_item,
    input  wire logic [mrds_pkg::DIM_W-1:0]   mesh_width,
    input  wire logic [mrds_pkg::DIM_W-1:0]   mesh_height,
    input  wire logic                         broadcast_mode,
    output logic                              s1_valid,
    output mrds_pkg::s1_t                     s1_data
);
    import mrds_pkg::*;

    logic             valid_reg;
    logic             valid_next;
    s1_t              data_reg;
    s1_t              data_next;

    // Clamp a dimension register to 1..MAX_MESH_DIM
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        if (v == '0)
        begin
            return DIM_W'(1);
        end
        else if (32'(v) > MAX_MESH_DIM)
        begin
            return DIM_W'(MAX_MESH_DIM);
        end
        return v;
    endfunction

    // Build the next stage contents
    always_comb
    begin
        valid_next          = in_valid;
        data_next.item      = in_item;
        data_next.w         = eff_dim(mesh_width);
        data_next.h         = eff_dim(mesh_height);
        data_next.path_mode = broadcast_mode;
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign s1_valid = valid_reg;
    assign s1_data  = data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mrds_label.sv
// Label stage: snake labels, unicast and tree masks, path neighbour directions.
// Depends on mrds_pkg.
`default_nettype none

module mrds_label (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           s1_valid,
    input  wire mrds_pkg::s1_t  s1_data,
    output logic                s2_valid,
    output mrds_pkg::s2_t       s2_data
);
    import mrds_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    s2_t        data_reg;
    s2_t        data_next;

    logic [DIM_W-1:0]   cx;
    logic [DIM_W-1:0]   cy;
    logic [DIM_W-1:0]   sx;
    logic [DIM_W-1:0]   sy;
    logic [DIM_W-1:0]   dx;
    logic [DIM_W-1:0]   dy;
    logic [DIM_W-1:0]   w_last;
    logic [DIM_W-1:0]   h_last;
    logic               even_row;
    logic               end_fwd;
    logic               end_bwd;
    logic [MASK_W-1:0]  uni;
    logic [MASK_W-1:0]  tree;

    always_comb
    begin
        cx     = DIM_W'(s1_data.item.cur_x);
        cy     = DIM_W'(s1_data.item.cur_y);
        sx     = DIM_W'(s1_data.item.src_x);
        sy     = DIM_W'(s1_data.item.src_y);
        dx     = DIM_W'(s1_data.item.dst_x);
        dy     = DIM_W'(s1_data.item.dst_y);
        w_last = s1_data.w - DIM_W'(1);
        h_last = s1_data.h - DIM_W'(1);

        // XY order for unicast
        if (dx > cx)
        begin
            uni = PORT_EAST;
        end
        else if (dx < cx)
        begin
            uni = PORT_WEST;
        end
        else if (dy > cy)
        begin
            uni = PORT_SOUTH;
        end
        else
        begin
            uni = PORT_NORTH;
        end

        // Tree broadcast: columns everywhere, row only on the source row
        tree = PORT_NONE;
        if (cy >= sy && cy < h_last)
        begin
            tree = tree | PORT_SOUTH;
        end
        if (cy <= sy && cy != '0)
        begin
            tree = tree | PORT_NORTH;
        end
        if (cy == sy)
        begin
            if (cx >= sx && cx < w_last)
            begin
                tree = tree | PORT_EAST;
            end
            if (cx <= sx && cx != '0)
            begin
                tree = tree | PORT_WEST;
            end
        end

        // Path neighbours: along the row, or turn at the row end
        even_row = ~s1_data.item.cur_y[0];
        end_fwd  = even_row ? (cx == w_last) : (cx == '0);
        end_bwd  = even_row ? (cx == '0) : (cx == w_last);

        valid_next             = s1_valid;
        data_next.cur_label    = label_of(s1_data.item.cur_x, s1_data.item.cur_y, s1_data.w);
        data_next.home_label   = label_of(s1_data.item.src_x, s1_data.item.src_y, s1_data.w);
        data_next.is_broadcast = s1_data.item.is_broadcast;
        data_next.path_mode    = s1_data.path_mode;
        data_next.in_range     = (cx < s1_data.w) && (cy < s1_data.h)
                              && (sx < s1_data.w) && (sy < s1_data.h);
        data_next.at_first     = (cx == '0) && (cy == '0);
        data_next.at_last      = (cy == h_last) && end_fwd;
        data_next.fwd_dir      = end_fwd ? PORT_SOUTH : (even_row ? PORT_EAST : PORT_WEST);
        data_next.bwd_dir      = end_bwd ? PORT_NORTH : (even_row ? PORT_WEST : PORT_EAST);
        data_next.uni_mask     = uni;
        data_next.tree_mask    = tree;
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign s2_valid = valid_reg;
    assign s2_data  = data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mrds_merge.sv
// Output stage: compares path labels and selects the final port mask.
// Depends on mrds_pkg.
`default_nettype none

module mrds_merge (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s2_valid,
    input  wire mrds_pkg::s2_t                 s2_data,
    output logic                               done,
    output logic [mrds_pkg::MASK_W-1:0]        port_mask
);
    import mrds_pkg::*;

    logic               done_reg;
    logic               done_next;
    logic [MASK_W-1:0]  mask_reg;
    logic [MASK_W-1:0]  mask_next;
    logic [MASK_W-1:0]  path;

    always_comb
    begin
        // Forward toward label+1 and/or back toward label-1
        path = PORT_NONE;
        if (s2_data.in_range)
        begin
            if (s2_data.cur_label >= s2_data.home_label && !s2_data.at_last)
            begin
                path = path | s2_data.fwd_dir;
            end
            if (s2_data.cur_label <= s2_data.home_label && !s2_data.at_first)
            begin
                path = path | s2_data.bwd_dir;
            end
        end

        if (!s2_data.is_broadcast)
        begin
            mask_next = s2_data.uni_mask;
        end
        else if (s2_data.path_mode)
        begin
            mask_next = path;
        end
        else
        begin
            mask_next = s2_data.tree_mask;
        end
        done_next = s2_valid;
    end

    // Strobe the result for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        mask_reg <= mask_next;
    end

    assign done      = done_reg;
    assign port_mask = mask_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mesh_route_direction_select.sv
// Mesh route direction select: XY unicast routing and tree or snake-path broadcast.
// Flow: a request is registered in mrds_front, then in mrds_label, then in mrds_merge,
// whose registers drive done and port_mask with the result.
// Throughput: one request per cycle; three register stages, busy stays low.
// Reset: rst_n clears the stage valid bits and loads width 4, height 4, tree mode.
// Results cannot be held off by the receiver; done lasts exactly one cycle.
// Depends on mrds_pkg, mrds_front, mrds_label, mrds_merge.
`default_nettype none

module mesh_route_direction_select #(
    parameter int unsigned MAX_MESH_DIM = 16
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [mrds_pkg::COORD_W-1:0]       cur_x,
    input  wire logic [mrds_pkg::COORD_W-1:0]       cur_y,
    input  wire logic [mrds_pkg::COORD_W-1:0]       src_x,
    input  wire logic [mrds_pkg::COORD_W-1:0]       src_y,
    input  wire logic [mrds_pkg::COORD_W-1:0]       dst_x,
    input  wire logic [mrds_pkg::COORD_W-1:0]       dst_y,
    input  wire logic                               is_broadcast,
    output logic                                    done,
    output logic [mrds_pkg::MASK_W-1:0]             port_mask,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [mrds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [mrds_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import mrds_pkg::*;

    logic [DIM_W-1:0]   mesh_width_reg;
    logic [DIM_W-1:0]   mesh_width_next;
    logic [DIM_W-1:0]   mesh_height_reg;
    logic [DIM_W-1:0]   mesh_height_next;
    logic               broadcast_mode_reg;
    logic               broadcast_mode_next;
    item_t              in_item;
    logic               in_valid;
    logic               s1_valid;
    s1_t                s1_data;
    logic               s2_valid;
    s2_t                s2_data;

    // Pipeline never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign in_valid  = start & ~busy;

    // Decode register writes
    always_comb
    begin
        mesh_width_next     = mesh_width_reg;
        mesh_height_next    = mesh_height_reg;
        broadcast_mode_next = broadcast_mode_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MESH_WIDTH:     mesh_width_next     = DIM_W'(cfg_data);
                CFG_MESH_HEIGHT:    mesh_height_next    = DIM_W'(cfg_data);
                CFG_BROADCAST_MODE: broadcast_mode_next = cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mesh_width_reg     <= DIM_W'(4);
            mesh_height_reg    <= DIM_W'(4);
            broadcast_mode_reg <= 1'b0;
        end
        else
        begin
            mesh_width_reg     <= mesh_width_next;
            mesh_height_reg    <= mesh_height_next;
            broadcast_mode_reg <= broadcast_mode_next;
        end
    end

    // Gather the request beat
    always_comb
    begin
        in_item.cur_x        = cur_x;
        in_item.cur_y        = cur_y;
        in_item.src_x        = src_x;
        in_item.src_y        = src_y;
        in_item.dst_x        = dst_x;
        in_item.dst_y        = dst_y;
        in_item.is_broadcast = is_broadcast;
    end

    mrds_front #(
        .MAX_MESH_DIM (MAX_MESH_DIM)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_item        (in_item),
        .mesh_width     (mesh_width_reg),
        .mesh_height    (mesh_height_reg),
        .broadcast_mode (broadcast_mode_reg),
        .s1_valid       (s1_valid),
        .s1_data        (s1_data)
    );

    mrds_label u_label (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .s2_valid (s2_valid),
        .s2_data  (s2_data)
    );

    mrds_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_valid  (s2_valid),
        .s2_data   (s2_data),
        .done      (done),
        .port_mask (port_mask)
    );

endmodule

`default_nettype wire
